FILE: src/uniform_grid_binning_query_macros.svh
// Assertion macros for the grid binning block.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef UNIFORM_GRID_BINNING_QUERY_MACROS_SVH
`define UNIFORM_GRID_BINNING_QUERY_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define UGB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define UGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/ugbq_pkg.sv
// Shared constants, codes and types of the grid binning block.
// No dependencies.
package ugbq_pkg;
  localparam int unsigned MaxCols      = 16;
  localparam int unsigned MaxRows      = 16;
  localparam int unsigned MaxParticles = 64;
  localparam int unsigned NumCells     = MaxCols * MaxRows;
  localparam int unsigned CellW        = $clog2(NumCells);
  localparam int unsigned ColW         = $clog2(MaxCols);
  localparam int unsigned RowW         = $clog2(MaxRows);
  localparam int unsigned IdxW         = 6;
  localparam int unsigned CntW         = 7;

  localparam logic [1:0] ActClear  = 2'd0;
  localparam logic [1:0] ActInsert = 2'd1;
  localparam logic [1:0] ActQuery  = 2'd2;

  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegInvCell = 3'd2;
  localparam logic [2:0] RegCols    = 3'd3;
  localparam logic [2:0] RegRows    = 3'd4;

  // Request and reply of the cell mapping unit.
  typedef struct packed {
    logic               start;
    logic signed [33:0] diff;
    logic [8:0]         n;
  } map_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] bin_no;
  } map_rsp_t;
endpackage

FILE: src/ugbq_cell_map.sv
// Multi-cycle mapping of an axis offset to a clamped cell number.
// Depends on ugbq_pkg. The product is formed in two halves, 16x32 low and 17x32 high.
module ugbq_cell_map (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  ugbq_pkg::map_req_t req_i,
  output ugbq_pkg::map_rsp_t rsp_o,
  input  logic [31:0]        inv_i
);
  import ugbq_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhMul  = 2'd1;
  localparam logic [1:0] PhOut  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [16:0] hi_q;
  logic [48:0] lo_prod_q;
  logic        neg_q;
  logic [8:0]  n_q;
  logic [49:0] prod_hi;
  logic [65:0] total;
  logic [49:0] q;
  logic [7:0]  bin_d, bin_q;
  logic        done_q;

  always_comb begin
    phase_d = phase_q;
    if (flush_i) begin
      phase_d = PhIdle;
    end else if (req_i.start) begin
      phase_d = PhMul;
    end else if (phase_q == PhMul) begin
      phase_d = PhOut;
    end else if (phase_q == PhOut) begin
      phase_d = PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Low 16 fraction bits and the high part are multiplied in separate cycles.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q     <= (req_i.diff <= 34'sd0);
      hi_q      <= req_i.diff[32:16];
      lo_prod_q <= {17'd0, req_i.diff[15:0]} * {17'd0, inv_i};
      n_q       <= req_i.n;
    end
  end

  assign prod_hi = {1'b0, hi_q} * {18'd0, inv_i};
  // high product plus the low product with its 16 fraction bits dropped
  assign total   = {16'd0, prod_hi} + {33'd0, lo_prod_q[48:16]};
  assign q       = total[65:16];

  always_comb begin
    if (neg_q || n_q == 9'd0) begin
      bin_d = 8'd0;
    end else if (q > {41'd0, n_q - 9'd1}) begin
      bin_d = 8'(n_q - 9'd1);
    end else begin
      bin_d = q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (phase_q == PhMul) && !flush_i;
    end
  end

  assign rsp_o = {done_q, bin_q};
endmodule

FILE: src/uniform_grid_binning_query.sv
// Grid binning: keeps up to 16x16 cells of particle lists and walks query windows.
// After reset and after each clear the block sweeps all 256 cells, one per cycle, and
// stalls the input meanwhile. An insert runs two axis mappings, one after the other,
// through the shared mapping unit, then a read-modify-write of the cell lists. A query
// runs four mappings for the window bounds, then reads and checks each visited cell,
// reads the link after each reported index but the last of a cell, and ends with the
// final beat; output stalls hold the walk. Clears, ignored inserts and unknown actions
// give no beats.
// Depends on ugbq_pkg, ugbq_cell_map and the assertion macro header.
`include "uniform_grid_binning_query_macros.svh"
module uniform_grid_binning_query (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [30:0] radius_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  particle_index_o,
  output logic        found_o,
  output logic        last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ugbq_pkg::*;

  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StClr   = 5'd1;
  localparam logic [4:0] StMapX  = 5'd2;
  localparam logic [4:0] StWaitX = 5'd3;
  localparam logic [4:0] StMapY  = 5'd4;
  localparam logic [4:0] StWaitY = 5'd5;
  localparam logic [4:0] StInsRd = 5'd6;
  localparam logic [4:0] StInsWr = 5'd7;
  localparam logic [4:0] StQSx   = 5'd8;
  localparam logic [4:0] StQSxW  = 5'd9;
  localparam logic [4:0] StQSy   = 5'd10;
  localparam logic [4:0] StQSyW  = 5'd11;
  localparam logic [4:0] StQEx   = 5'd12;
  localparam logic [4:0] StQExW  = 5'd13;
  localparam logic [4:0] StQEy   = 5'd14;
  localparam logic [4:0] StQEyW  = 5'd15;
  localparam logic [4:0] StCellRd = 5'd16;
  localparam logic [4:0] StCellCk = 5'd17;
  localparam logic [4:0] StEmit   = 5'd18;
  localparam logic [4:0] StNextRd = 5'd19;
  localparam logic [4:0] StAdvCell = 5'd20;
  localparam logic [4:0] StNone   = 5'd21;
  localparam logic [4:0] StFlush  = 5'd22;

  logic [4:0] st_q, st_d;

  logic signed [31:0] origin_x_q, origin_y_q;
  logic [31:0]        inv_q;
  logic [4:0]         cols_q, rows_q;
  logic [4:0]         ecols, erows;

  logic signed [31:0] px_q, py_q;
  logic [30:0]        r_q;

  logic [ColW-1:0] cx_q, sx_q, ex_q;
  logic [RowW-1:0] cy_q, sy_q, ey_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] nout_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] tail_q;
  logic [CellW-1:0] clr_q;
  logic            any_q;
  logic [CellW-1:0] cur_cell;

  // Cell store: used, head, tail in one word; link store separately.
  logic [2*IdxW:0] cell_mem [NumCells];
  logic [IdxW-1:0] next_mem [MaxParticles];
  logic [2*IdxW:0] cell_rd_q;
  logic [IdxW-1:0] next_rd_q;
  logic            cell_we, cell_re, next_we, next_re;
  logic [CellW-1:0] cell_wa, cell_ra;
  logic [2*IdxW:0] cell_wd;
  logic [IdxW-1:0] next_wa, next_wd, next_ra;

  map_req_t map_req;
  map_rsp_t map_rsp;
  logic [7:0] mcell;

  logic out_full_q;
  logic [5:0] out_idx_q;
  logic out_found_q, out_last_q;
  logic out_free;
  logic emit;
  logic [5:0] emit_idx;
  logic emit_found, emit_last;
  logic hold_ld;
  logic hold_q;
  logic [5:0] hold_idx_q;
  logic in_acc;

  assign ecols = (cols_q > 5'(MaxCols)) ? 5'(MaxCols) : cols_q;
  assign erows = (rows_q > 5'(MaxRows)) ? 5'(MaxRows) : rows_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_q      <= 32'd65536;
      cols_q     <= '0;
      rows_q     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        RegOriginX: origin_x_q <= cfg_data_i;
        RegOriginY: origin_y_q <= cfg_data_i;
        RegInvCell: inv_q      <= cfg_data_i;
        RegCols:    cols_q     <= cfg_data_i[4:0];
        RegRows:    rows_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  ugbq_cell_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flush_i(1'b0),
    .req_i  (map_req),
    .rsp_o  (map_rsp),
    .inv_i  (inv_q)
  );
  assign mcell = map_rsp.bin_no;

  assign in_stall = (st_q != StIdle);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_full_q || !out_stall;

  // Mapping requests per state.
  always_comb begin
    map_req = '0;
    case (st_q)
      StMapX: begin
        map_req.start = 1'b1;
        map_req.diff  = 34'(px_q) - 34'(origin_x_q);
        map_req.n     = {4'd0, ecols};
      end
      StMapY: begin
        map_req.start = 1'b1;
        map_req.diff  = 34'(py_q) - 34'(origin_y_q);
        map_req.n     = {4'd0, erows};
      end
      StQSx: begin
        map_req.start = 1'b1;
        map_req.diff  = 34'(px_q) - 34'({1'b0, r_q}) - 34'(origin_x_q);
        map_req.n     = {4'd0, ecols};
      end
      StQSy: begin
        map_req.start = 1'b1;
        map_req.diff  = 34'(py_q) - 34'({1'b0, r_q}) - 34'(origin_y_q);
        map_req.n     = {4'd0, erows};
      end
      StQEx: begin
        map_req.start = 1'b1;
        map_req.diff  = 34'(px_q) + 34'({1'b0, r_q}) - 34'(origin_x_q);
        map_req.n     = {4'd0, ecols};
      end
      StQEy: begin
        map_req.start = 1'b1;
        map_req.diff  = 34'(py_q) + 34'({1'b0, r_q}) - 34'(origin_y_q);
        map_req.n     = {4'd0, erows};
      end
      default: ;
    endcase
  end

  // Linear cell address: cy*cols + cx, cols at most 16.
  assign cur_cell = CellW'({4'd0, cy_q} * {4'd0, ecols} + {4'd0, cx_q});

  always_comb begin
    st_d = st_q;
    cell_we = 1'b0; cell_wa = cur_cell; cell_wd = '0;
    cell_re = 1'b0; cell_ra = cur_cell;
    next_we = 1'b0; next_wa = tail_q; next_wd = count_q[IdxW-1:0];
    next_re = 1'b0; next_ra = idx_q;
    emit = 1'b0; emit_idx = hold_idx_q; emit_found = 1'b1; emit_last = 1'b0;
    hold_ld = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid) begin
          if (action_i == ActClear) begin
            st_d = StClr;
          end else if (action_i == ActInsert) begin
            if (ecols != 5'd0 && erows != 5'd0 && count_q < CntW'(MaxParticles)) begin
              st_d = StMapX;
            end
          end else if (action_i == ActQuery) begin
            if (ecols != 5'd0 && erows != 5'd0 && radius_i != 31'd0) begin
              st_d = StQSx;
            end else begin
              st_d = StNone;
            end
          end
        end
      end
      StClr: begin
        cell_we = 1'b1; cell_wa = clr_q; cell_wd = '0;
        if (clr_q == CellW'(NumCells - 1)) st_d = StIdle;
      end
      StMapX:  st_d = StWaitX;
      StWaitX: if (map_rsp.done) st_d = StMapY;
      StMapY:  st_d = StWaitY;
      StWaitY: if (map_rsp.done) st_d = StInsRd;
      StInsRd: begin
        cell_re = 1'b1;
        st_d = StInsWr;
      end
      StInsWr: begin
        cell_we = 1'b1;
        if (cell_rd_q[2*IdxW]) begin
          next_we = 1'b1; next_wa = cell_rd_q[IdxW-1:0];
          cell_wd = {1'b1, cell_rd_q[2*IdxW-1:IdxW], count_q[IdxW-1:0]};
        end else begin
          cell_wd = {1'b1, count_q[IdxW-1:0], count_q[IdxW-1:0]};
        end
        st_d = StIdle;
      end
      StQSx: st_d = StQSxW;
      StQSxW: if (map_rsp.done) st_d = StQSy;
      StQSy: st_d = StQSyW;
      StQSyW: if (map_rsp.done) st_d = StQEx;
      StQEx: st_d = StQExW;
      StQExW: if (map_rsp.done) st_d = StQEy;
      StQEy: st_d = StQEyW;
      StQEyW: if (map_rsp.done) st_d = StCellRd;
      StCellRd: begin
        cell_re = 1'b1;
        st_d = StCellCk;
      end
      StCellCk: begin
        if (cell_rd_q[2*IdxW]) st_d = StEmit;
        else st_d = StAdvCell;
      end
      StEmit: begin
        // hold this index back and pass the one held before to the output
        if (out_free) begin
          hold_ld = 1'b1;
          emit    = hold_q;
          if (idx_q == tail_q || nout_q == CntW'(MaxParticles - 1)) begin
            if (nout_q == CntW'(MaxParticles - 1) || (cx_q == ex_q && cy_q == ey_q)) begin
              st_d = StFlush;
            end else begin
              st_d = StAdvCell;
            end
          end else begin
            next_re = 1'b1;
            st_d = StNextRd;
          end
        end
      end
      StNextRd: st_d = StEmit;
      StAdvCell: begin
        if (cx_q == ex_q && cy_q == ey_q) begin
          st_d = any_q ? StFlush : StNone;
        end else begin
          st_d = StCellRd;
        end
      end
      StFlush: begin
        if (out_free) begin
          emit = 1'b1; emit_last = 1'b1;
          st_d = StIdle;
        end
      end
      StNone: begin
        if (out_free) begin
          emit = 1'b1; emit_idx = '0; emit_found = 1'b0; emit_last = 1'b1;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (cell_re) cell_rd_q <= cell_mem[cell_ra];
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClr;
      clr_q   <= '0;
      count_q <= '0;
      nout_q  <= '0;
      any_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClr) clr_q <= clr_q + CellW'(1);
      if (in_acc) begin
        nout_q <= '0;
        any_q  <= 1'b0;
        clr_q  <= '0;
        if (action_i == ActClear) count_q <= '0;
      end
      if (st_q == StInsWr) count_q <= count_q + CntW'(1);
      if (hold_ld) begin
        nout_q <= nout_q + CntW'(1);
        any_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= pos_x_i; py_q <= pos_y_i; r_q <= radius_i;
    end
    if (st_q == StWaitX && map_rsp.done) cx_q <= mcell[ColW-1:0];
    if (st_q == StWaitY && map_rsp.done) cy_q <= mcell[RowW-1:0];
    if (st_q == StQSxW && map_rsp.done) begin
      sx_q <= mcell[ColW-1:0]; cx_q <= mcell[ColW-1:0];
    end
    if (st_q == StQSyW && map_rsp.done) begin
      sy_q <= mcell[RowW-1:0]; cy_q <= mcell[RowW-1:0];
    end
    if (st_q == StQExW && map_rsp.done) ex_q <= mcell[ColW-1:0];
    if (st_q == StQEyW && map_rsp.done) ey_q <= mcell[RowW-1:0];
    if (st_q == StCellCk) begin
      idx_q  <= cell_rd_q[2*IdxW-1:IdxW];
      tail_q <= cell_rd_q[IdxW-1:0];
    end
    if (st_q == StNextRd) idx_q <= next_rd_q;
    if (st_q == StAdvCell && !(cx_q == ex_q && cy_q == ey_q)) begin
      if (cx_q == ex_q) begin
        cx_q <= sx_q; cy_q <= cy_q + RowW'(1);
      end else begin
        cx_q <= cx_q + ColW'(1);
      end
    end
  end

  // Output register. Each found index waits in the hold register so the
  // final one can be marked last once the walk knows nothing follows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
      hold_q     <= 1'b0;
    end else begin
      if (emit) out_full_q <= 1'b1;
      else if (!out_stall) out_full_q <= 1'b0;
      if (hold_ld) hold_q <= 1'b1;
      else if (emit && emit_last) hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_ld) hold_idx_q <= idx_q;
    if (emit) begin
      out_idx_q <= emit_idx; out_found_q <= emit_found; out_last_q <= emit_last;
    end
  end

  assign out_valid        = out_full_q;
  assign particle_index_o = out_idx_q;
  assign found_o          = out_found_q;
  assign last_o           = out_last_q;

  `UGB_ASSERT(a_no_in_busy, in_valid && !in_stall, st_q == StIdle, "accept while busy")
  `UGB_ASSERT(a_count_cap, 1'b1, count_q <= CntW'(MaxParticles), "count over capacity")
  `UGB_ASSERT_NEXT(a_ins_count, st_q == StInsWr, count_q == $past(count_q) + CntW'(1),
                   "insert did not advance count")
  `UGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(particle_index_o) && $stable(last_o), "stalled beat changed")
endmodule
